>>> sv/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Types and constants shared by the floppy controller register file.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

  localparam int OUT_ADDR_W = 23;
  localparam int FMT_W      = 2;
  localparam int MEDIA_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam int BC_W       = 10;
  localparam int SEL_W      = 3;

  typedef struct packed {
    logic             mode;
    logic [SEL_W-1:0] reg_select;
    logic [7:0]       write_data;
    logic [7:0]       media_byte;
  } fdc_in_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic [OUT_ADDR_W-1:0] media_address;
    logic                  media_read;
    logic                  media_write;
    logic [7:0]            media_write_data;
    logic                  media_flush;
  } fdc_out_t;

  // bus access kind
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // register selects
  localparam logic [SEL_W-1:0] REG_CMD    = 3'd0;
  localparam logic [SEL_W-1:0] REG_TRACK  = 3'd1;
  localparam logic [SEL_W-1:0] REG_SECTOR = 3'd2;
  localparam logic [SEL_W-1:0] REG_DATA   = 3'd3;
  localparam logic [SEL_W-1:0] REG_CTRL1  = 3'd4;
  localparam logic [SEL_W-1:0] REG_CTRL2  = 3'd5;
  localparam logic [SEL_W-1:0] REG_FLAGS  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRV0_FMT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV1_FMT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV0_MEDIA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV1_MEDIA = 2'd3;

  // geometry formats
  localparam logic [FMT_W-1:0] FMT_2S9 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_1S9 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_2S8 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_1S8 = 2'd3;

  // media states
  localparam logic [MEDIA_W-1:0] MEDIA_NONE     = 2'd0;
  localparam logic [MEDIA_W-1:0] MEDIA_WRITABLE = 2'd1;

  // command opcodes (upper nibble)
  localparam logic [3:0] OP_RESTORE   = 4'h0;
  localparam logic [3:0] OP_SEEK      = 4'h1;
  localparam logic [3:0] OP_STEP      = 4'h2;
  localparam logic [3:0] OP_STEP_U    = 4'h3;
  localparam logic [3:0] OP_STEP_IN   = 4'h4;
  localparam logic [3:0] OP_STEP_IN_U = 4'h5;
  localparam logic [3:0] OP_STEP_OUT  = 4'h6;
  localparam logic [3:0] OP_STEP_OUTU = 4'h7;
  localparam logic [3:0] OP_READ      = 4'h8;
  localparam logic [3:0] OP_READ_M    = 4'h9;
  localparam logic [3:0] OP_WRITE     = 4'hA;
  localparam logic [3:0] OP_WRITE_M   = 4'hB;
  localparam logic [3:0] OP_FORCE_INT = 4'hD;

  localparam logic [7:0] CMD_CLASS_MASK = 8'hE0;
  localparam logic [7:0] CMD_CLASS_READ = 8'h80;
  localparam logic [7:0] CMD_CLASS_WRITE = 8'hA0;
  localparam int         CMD_MULTI_BIT  = 4;

  // status codes
  localparam logic [7:0] ST_CLEAR     = 8'h00;
  localparam logic [7:0] ST_NOT_READY = 8'h80;
  localparam logic [7:0] ST_WPROT     = 8'h40;
  localparam logic [7:0] ST_TRACK0    = 8'h06;
  localparam logic [7:0] ST_SEEK_ERR  = 8'h10;
  localparam logic [7:0] ST_XFER      = 8'h03;
  localparam logic [7:0] ST_WP_FAULT  = 8'h43;
  localparam logic [7:0] ST_IDLE      = 8'h02;

  localparam logic [7:0] CTRL2_RD_MASK = 8'hFB;
  localparam logic [7:0] DATA_NO_MEDIA = 8'hFF;
  localparam logic [7:0] TRACK_LIMIT   = 8'd80;

  // request flags
  localparam logic [1:0] FLAG_NONE = 2'b00;
  localparam logic [1:0] FLAG_IRQ  = 2'b01;
  localparam logic [1:0] FLAG_DRQ  = 2'b10;

  localparam logic [BC_W-1:0] BC_MAX = 10'h3FF;

endpackage

`default_nettype wire

>>> sv/fdc_chan_if.sv
// ----------------------------------------------------------------------------
// fdc_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/fdc_locate.sv
// ----------------------------------------------------------------------------
// fdc_locate
// Image byte offset of a sector from drive geometry, track, head and sector.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_locate #(
  parameter int SECTOR_BYTES = 512,
  parameter int ADDRESS_BITS = 23
) (
  input  wire logic [fdc_pkg::FMT_W-1:0] format,
  input  wire logic [7:0]                track,
  input  wire logic                      head,
  input  wire logic [7:0]                sector,
  output logic      [ADDRESS_BITS-1:0]   base
);
  import fdc_pkg::*;

  localparam int IDX_W = 13;

  logic [IDX_W-1:0]        track_mul;
  logic [IDX_W-1:0]        head_mul;
  logic [IDX_W-1:0]        idx;
  logic [ADDRESS_BITS-1:0] idx_m1;

  always_comb begin
    unique case (format)
      FMT_2S9: begin
        track_mul = IDX_W'(track) * IDX_W'(18);
        head_mul  = head ? IDX_W'(9) : '0;
      end
      FMT_1S9: begin
        track_mul = IDX_W'(track) * IDX_W'(9);
        head_mul  = '0;
      end
      FMT_2S8: begin
        track_mul = IDX_W'(track) * IDX_W'(16);
        head_mul  = head ? IDX_W'(8) : '0;
      end
      FMT_1S8: begin
        track_mul = IDX_W'(track) * IDX_W'(8);
        head_mul  = '0;
      end
      default: begin
        track_mul = '0;
        head_mul  = '0;
      end
    endcase
    idx    = track_mul + head_mul + IDX_W'(sector);
    idx_m1 = ADDRESS_BITS'(idx) - ADDRESS_BITS'(1);
    base   = ADDRESS_BITS'(idx_m1 * ADDRESS_BITS'(SECTOR_BYTES));
  end

endmodule

`default_nettype wire

>>> sv/fdc_regs.sv
// ----------------------------------------------------------------------------
// fdc_regs
// Controller register file: bus access decode, commands and sector transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_regs #(
  parameter int SECTOR_BYTES = 512,
  parameter int ADDRESS_BITS = 23
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [fdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           proc,
  input  wire fdc_pkg::fdc_in_t               item,
  output fdc_pkg::fdc_out_t                   result
);
  import fdc_pkg::*;

  localparam logic [BC_W-1:0] SB_COUNT = BC_W'(SECTOR_BYTES);

  logic [FMT_W-1:0]   fmt0_r, fmt1_r;
  logic [MEDIA_W-1:0] media0_r, media1_r;

  logic [7:0]              command_r, command_nxt;
  logic [7:0]              status_r, status_nxt;
  logic [1:0]              flags_r, flags_nxt;
  logic [7:0]              track_r, track_nxt;
  logic [7:0]              sector_r, sector_nxt;
  logic [7:0]              data_r, data_nxt;
  logic [7:0]              ctrl1_r, ctrl1_nxt;
  logic [7:0]              ctrl2_r, ctrl2_nxt;
  logic                    step_out_r, step_out_nxt;
  logic [7:0]              head_track_r [2];
  logic [7:0]              head_track_nxt [2];
  logic [BC_W-1:0]         byte_count_r, byte_count_nxt;
  logic [ADDRESS_BITS-1:0] sector_base_r, sector_base_nxt;

  logic                    drv;
  logic [MEDIA_W-1:0]      media;
  logic [FMT_W-1:0]        fmt;
  logic [7:0]              loc_sector;
  logic [ADDRESS_BITS-1:0] loc_base;
  logic [ADDRESS_BITS-1:0] addr_sum;
  logic [BC_W-1:0]         bc_inc;
  logic                    end_before, end_after;
  logic [3:0]              opcode;
  logic                    so;
  logic [7:0]              track_step;

  assign drv        = ctrl2_r[0];
  assign media      = drv ? media1_r : media0_r;
  assign fmt        = drv ? fmt1_r : fmt0_r;
  assign loc_sector = (item.reg_select == REG_DATA) ? sector_r + 8'd1 : sector_r;
  assign addr_sum   = sector_base_r + ADDRESS_BITS'(byte_count_r);
  assign bc_inc     = (byte_count_r == BC_MAX) ? byte_count_r : byte_count_r + BC_W'(1);
  assign end_before = (byte_count_r == SB_COUNT);
  assign end_after  = (bc_inc == SB_COUNT);
  assign opcode     = item.write_data[7:4];

  fdc_locate #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_locate (
    .format (fmt),
    .track  (head_track_r[drv]),
    .head   (ctrl1_r[0]),
    .sector (loc_sector),
    .base   (loc_base)
  );

  always_comb begin
    command_nxt       = command_r;
    status_nxt        = status_r;
    flags_nxt         = flags_r;
    track_nxt         = track_r;
    sector_nxt        = sector_r;
    data_nxt          = data_r;
    ctrl1_nxt         = ctrl1_r;
    ctrl2_nxt         = ctrl2_r;
    step_out_nxt      = step_out_r;
    head_track_nxt[0] = head_track_r[0];
    head_track_nxt[1] = head_track_r[1];
    byte_count_nxt    = byte_count_r;
    sector_base_nxt   = sector_base_r;
    result            = '0;
    so                = step_out_r;
    track_step        = track_r;

    if (proc) begin
      if (item.mode == MODE_READ) begin
        unique case (item.reg_select)
          REG_CMD: begin
            result.read_data = (media != MEDIA_WRITABLE) ? (status_r | ST_WPROT) : status_r;
          end
          REG_TRACK:  result.read_data = track_r;
          REG_SECTOR: result.read_data = sector_r;
          REG_DATA: begin
            if (media == MEDIA_NONE) begin
              result.read_data = DATA_NO_MEDIA;
            end else if ((command_r & CMD_CLASS_MASK) != CMD_CLASS_READ) begin
              result.read_data = head_track_r[drv];
            end else begin
              if (end_before) status_nxt = ST_CLEAR;
              result.media_read    = 1'b1;
              result.media_address = OUT_ADDR_W'(addr_sum);
              result.read_data     = item.media_byte;
              byte_count_nxt       = bc_inc;
              flags_nxt            = FLAG_DRQ;
              if (end_after) begin
                if (command_r[CMD_MULTI_BIT]) begin
                  sector_nxt      = sector_r + 8'd1;
                  sector_base_nxt = loc_base;
                  byte_count_nxt  = '0;
                end else begin
                  flags_nxt  = FLAG_IRQ;
                  status_nxt = ST_CLEAR;
                end
              end
            end
          end
          REG_CTRL1: result.read_data = ctrl1_r;
          REG_CTRL2: result.read_data = ctrl2_r & CTRL2_RD_MASK;
          REG_FLAGS: result.read_data = {~flags_r[1], ~flags_r[0], 6'b0};
          default:   result.read_data = 8'h00;
        endcase
      end else begin
        unique case (item.reg_select)
          REG_CMD: begin
            command_nxt = item.write_data;
            if (media == MEDIA_NONE) begin
              status_nxt = ST_NOT_READY;
              flags_nxt  = FLAG_IRQ;
            end else begin
              unique case (opcode)
                OP_RESTORE: begin
                  track_nxt           = 8'd0;
                  data_nxt            = 8'd0;
                  flags_nxt           = FLAG_IRQ;
                  head_track_nxt[drv] = 8'd0;
                  status_nxt          = ST_TRACK0;
                end
                OP_SEEK: begin
                  flags_nxt           = FLAG_IRQ;
                  track_nxt           = data_r;
                  head_track_nxt[drv] = data_r;
                  status_nxt          = (data_r == 8'd0) ? ST_TRACK0 : ST_CLEAR;
                end
                OP_STEP, OP_STEP_IN, OP_STEP_OUT: begin
                  flags_nxt           = FLAG_IRQ;
                  status_nxt          = (track_r == 8'd0) ? ST_TRACK0 : ST_CLEAR;
                  head_track_nxt[drv] = track_r;
                end
                OP_STEP_U, OP_STEP_IN_U, OP_STEP_OUTU: begin
                  flags_nxt = FLAG_IRQ;
                  if (opcode == OP_STEP_IN_U) so = 1'b0;
                  if (opcode == OP_STEP_OUTU) so = 1'b1;
                  step_out_nxt = so;
                  if (!so) begin
                    status_nxt = (track_r == TRACK_LIMIT) ? ST_SEEK_ERR : ST_CLEAR;
                    track_step = track_r + 8'd1;
                  end else begin
                    status_nxt = ST_CLEAR;
                    track_step = track_r - 8'd1;
                  end
                  track_nxt           = track_step;
                  head_track_nxt[drv] = track_step;
                end
                OP_READ, OP_READ_M, OP_WRITE, OP_WRITE_M: begin
                  flags_nxt       = FLAG_DRQ;
                  sector_base_nxt = loc_base;
                  byte_count_nxt  = '0;
                  status_nxt      = ST_XFER;
                end
                OP_FORCE_INT: begin
                  flags_nxt  = (item.write_data[3:0] != 4'h0) ? FLAG_IRQ : FLAG_NONE;
                  status_nxt = ST_IDLE;
                end
                default: begin
                  flags_nxt  = FLAG_IRQ;
                  status_nxt = ST_NOT_READY;
                end
              endcase
            end
          end
          REG_TRACK:  track_nxt  = item.write_data;
          REG_SECTOR: sector_nxt = item.write_data;
          REG_DATA: begin
            if ((command_r & CMD_CLASS_MASK) != CMD_CLASS_WRITE) begin
              data_nxt = item.write_data;
            end else if (media != MEDIA_WRITABLE) begin
              flags_nxt      = FLAG_DRQ;
              status_nxt     = ST_WP_FAULT;
              byte_count_nxt = bc_inc;
              if (end_after) begin
                flags_nxt  = FLAG_IRQ;
                status_nxt = ST_WPROT;
              end
            end else begin
              if (end_before) status_nxt = ST_CLEAR;
              result.media_write      = 1'b1;
              result.media_write_data = item.write_data;
              result.media_address    = OUT_ADDR_W'(addr_sum);
              byte_count_nxt          = bc_inc;
              flags_nxt               = FLAG_DRQ;
              if (end_after) begin
                result.media_flush = 1'b1;
                if (command_r[CMD_MULTI_BIT]) begin
                  sector_nxt      = sector_r + 8'd1;
                  sector_base_nxt = loc_base;
                  byte_count_nxt  = '0;
                end else begin
                  flags_nxt   = FLAG_IRQ;
                  status_nxt  = ST_CLEAR;
                  command_nxt = 8'h00;
                end
              end
            end
          end
          REG_CTRL1: ctrl1_nxt = item.write_data;
          REG_CTRL2: ctrl2_nxt = item.write_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt0_r   <= '0;
      fmt1_r   <= '0;
      media0_r <= '0;
      media1_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRV0_FMT:   fmt0_r   <= cfg_data;
        CFG_DRV1_FMT:   fmt1_r   <= cfg_data;
        CFG_DRV0_MEDIA: media0_r <= cfg_data;
        CFG_DRV1_MEDIA: media1_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r       <= '0;
      status_r        <= '0;
      flags_r         <= '0;
      track_r         <= '0;
      sector_r        <= '0;
      data_r          <= '0;
      ctrl1_r         <= '0;
      ctrl2_r         <= '0;
      step_out_r      <= 1'b0;
      head_track_r[0] <= '0;
      head_track_r[1] <= '0;
      byte_count_r    <= '0;
      sector_base_r   <= '0;
    end else begin
      command_r       <= command_nxt;
      status_r        <= status_nxt;
      flags_r         <= flags_nxt;
      track_r         <= track_nxt;
      sector_r        <= sector_nxt;
      data_r          <= data_nxt;
      ctrl1_r         <= ctrl1_nxt;
      ctrl2_r         <= ctrl2_nxt;
      step_out_r      <= step_out_nxt;
      head_track_r[0] <= head_track_nxt[0];
      head_track_r[1] <= head_track_nxt[1];
      byte_count_r    <= byte_count_nxt;
      sector_base_r   <= sector_base_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/floppy_controller_registers.sv
// ----------------------------------------------------------------------------
// floppy_controller_registers
// Floppy disk controller register file with a valid/ready bus access channel.
//
// in_chan carries one bus access per item: mode, reg_select, write_data and
// the image byte media_byte. out_chan returns one item per access: read_data,
// the image byte address and the media read/write/flush strobes.
// The cfg port writes the per-drive geometry format and media state; write
// it only while no access is in flight.
// The access is captured in an input register, decoded against the register
// file in one pass, and the result is held in an output register. Throughput
// is one item per cycle while out_chan does not stall, set by the update of
// the register file between those two registers.
// Reset clears every controller register, the drive configuration and the
// valid flags of both pipeline stages. When out_chan stalls, the result holds
// in the output register, one more access waits in the input register, and
// in_chan.ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module floppy_controller_registers #(
  parameter int SECTOR_BYTES = 512,
  parameter int ADDRESS_BITS = 23
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fdc_chan_if.sink                            in_chan,
  fdc_chan_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [fdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  fdc_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  fdc_out_t out_item_r;
  fdc_out_t result;
  logic     advance;
  logic     proc;
  logic     in_accept;

  assign advance   = !out_valid_r || out_chan.ready;
  assign proc      = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_accept = in_chan.valid && in_chan.ready;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  fdc_regs #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .proc      (proc),
    .item      (s1_item_r),
    .result    (result)
  );

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = proc ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_item_r <= in_chan.payload;
    if (proc) out_item_r <= result;
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while both stages are held");

  a_proc_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_valid_r)
    else $error("processed item did not reach the output register");

  a_read_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.media_read && out_item_r.media_write))
    else $error("media read and write in the same item");

  a_flush_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.media_flush) |-> out_item_r.media_write)
    else $error("sector flush without a media write");

endmodule

`default_nettype wire
